>>> design/pfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// types and constants shared by the page frame pool blocks
// ----------------------------------------------------------------------------
package pfp_pkg;

	localparam int FRAMES       = 16;
	localparam int PAGE_ID_BITS = 32;
	localparam int PIN_BITS     = 8;
	localparam int STAMP_BITS   = 64;
	localparam int IDX_BITS     = $clog2(FRAMES);

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_FLUSH   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_POOL_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_FLUSH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [PAGE_ID_BITS-1:0] page_id;
		logic                    for_write;
	} in_word_t;

	typedef struct packed {
		logic [1:0]              status;
		logic                    hit;
		logic [3:0]              frame_index;
		logic                    write_back;
		logic [PAGE_ID_BITS-1:0] write_back_page;
		logic                    last;
	} out_word_t;

	// scan token travelling down the chain of frame cells
	typedef struct packed {
		logic                    found;
		logic [IDX_BITS-1:0]     found_idx;
		logic                    vic_ok;
		logic [IDX_BITS-1:0]     vic_idx;
		logic [STAMP_BITS-1:0]   vic_stamp;
		logic                    vic_dirty;
		logic [PAGE_ID_BITS-1:0] vic_page;
	} scan_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                    hit_upd;
		logic                    install;
		logic                    pin_inc;
		logic                    pin_dec;
		logic                    clean;
		logic [IDX_BITS-1:0]     idx;
		logic [PAGE_ID_BITS-1:0] page;
		logic                    dirty;
		logic [STAMP_BITS-1:0]   stamp;
	} cmd_t;

	typedef struct packed {
		logic [PAGE_ID_BITS-1:0] page;
		logic [PIN_BITS-1:0]     pins;
		logic                    dirty;
	} frame_view_t;

endpackage

>>> design/pfp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_stream_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface pfp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> design/page_frame_pool_lru_pinning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_pool_lru_pinning_core
// page frame pool with lru replacement and pin counts, chain of frame cells
// ----------------------------------------------------------------------------
// acquire, pin, release: result follows the scan, the apply step and the
//   output register (token moves one cell per cycle down the chain of cells)
// one item at a time, input taken once the result is gone
// flush: one word per dirty frame, then the done word once the last frame
//   has been visited; output stalls hold the walk
// reset: all frames empty, pins, dirty marks, stamps and clock zero
module page_frame_pool_lru_pinning_core (
	input  logic         clk,
	input  logic         arst_n,
	pfp_stream_if.sink   in_ch,
	pfp_stream_if.source out_ch
);
	import pfp_pkg::*;

	state_t   state_q, state_d;
	in_word_t req_q;
	scan_t    scan_s1;
	scan_t    chain [FRAMES+1];
	cmd_t     cmd;
	frame_view_t views [FRAMES];
	logic [STAMP_BITS-1:0] clock_q;
	logic [IDX_BITS-1:0]   fidx_q;
	logic [IDX_BITS:0]     scan_cnt_q;
	out_word_t out_q, res_d;
	logic     out_v_q;
	logic     flush_end, flush_emit, scan_done;

	assign chain[0] = '0;
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		pfp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.my_idx   (IDX_BITS'(g)),
			.key      (req_q.page_id),
			.scan_in  (chain[g]),
			.scan_out (chain[g+1]),
			.cmd      (cmd),
			.view     (views[g])
		);
	end

	assign in_ch.ready  = (state_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;
	assign flush_emit   = views[fidx_q].dirty;
	assign flush_end    = (fidx_q == IDX_BITS'(FRAMES-1));
	assign scan_done    = (scan_cnt_q == (IDX_BITS+1)'(FRAMES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_ch.valid && in_ch.ready)
				state_d = (in_ch.data.opcode == OP_FLUSH) ? S_FLUSH : S_SCAN;
			S_SCAN:  if (scan_done) state_d = S_APPLY;
			S_APPLY: state_d = S_OUT;
			S_FLUSH: if (!out_v_q || out_ch.ready) begin
				if (flush_end && !flush_emit) state_d = S_OUT;
			end
			S_OUT:   if (!out_v_q || out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd   = '0;
		res_d = '0;
		res_d.last = 1'b1;
		cmd.page  = req_q.page_id;
		cmd.dirty = req_q.for_write;
		cmd.stamp = clock_q + 1'b1;
		case (state_q)
			S_APPLY: begin
				if (req_q.opcode == OP_ACQUIRE) begin
					if (scan_s1.found) begin
						cmd.idx = scan_s1.found_idx;
						cmd.hit_upd = 1'b1;
						cmd.pin_inc = 1'b1;
						res_d.hit = 1'b1;
						res_d.frame_index = 4'(scan_s1.found_idx);
					end else if (scan_s1.vic_ok) begin
						cmd.idx = scan_s1.vic_idx;
						cmd.install = 1'b1;
						cmd.pin_inc = 1'b1;
						res_d.frame_index = 4'(scan_s1.vic_idx);
						res_d.write_back = scan_s1.vic_dirty;
						res_d.write_back_page = scan_s1.vic_dirty ?
							scan_s1.vic_page : '0;
					end else begin
						res_d.status = ST_POOL_FULL;
					end
				end else if (scan_s1.found) begin
					cmd.idx = scan_s1.found_idx;
					cmd.pin_inc = (req_q.opcode == OP_PIN);
					cmd.pin_dec = (req_q.opcode == OP_RELEASE);
					res_d.frame_index = 4'(scan_s1.found_idx);
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			S_FLUSH: begin
				cmd.idx = fidx_q;
				cmd.clean = flush_emit && (!out_v_q || out_ch.ready);
				res_d.last = 1'b0;
				res_d.frame_index = 4'(fidx_q);
				res_d.write_back = 1'b1;
				res_d.write_back_page = views[fidx_q].page;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clock_q    <= '0;
			fidx_q     <= '0;
			scan_cnt_q <= '0;
			out_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					fidx_q     <= '0;
					scan_cnt_q <= '0;
					if (out_ch.ready) out_v_q <= 1'b0;
				end
				S_SCAN: scan_cnt_q <= scan_cnt_q + 1'b1;
				S_APPLY: begin
					if (req_q.opcode == OP_ACQUIRE && (scan_s1.found || scan_s1.vic_ok))
						clock_q <= clock_q + 1'b1;
				end
				S_FLUSH: if (!out_v_q || out_ch.ready) begin
					out_v_q <= flush_emit;
					if (!flush_end) fidx_q <= fidx_q + 1'b1;
				end
				S_OUT: if (!out_v_q || out_ch.ready) out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid && in_ch.ready) req_q <= in_ch.data;
		if (state_q == S_SCAN && scan_done) scan_s1 <= chain[FRAMES];
		if (state_q == S_APPLY) out_q <= res_d;
		if (state_q == S_FLUSH && (!out_v_q || out_ch.ready)) begin
			if (flush_emit) out_q <= res_d;
			else if (flush_end) out_q <= '{status: ST_OK, last: 1'b1, default: '0};
		end
	end
endmodule

>>> design/pfp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_cell
// one page frame: holds its state, merges its view into the scan token and
// registers the token toward the next cell
// ----------------------------------------------------------------------------
module pfp_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pfp_pkg::IDX_BITS-1:0]      my_idx,
	input  logic [pfp_pkg::PAGE_ID_BITS-1:0]  key,
	input  pfp_pkg::scan_t                    scan_in,
	output pfp_pkg::scan_t                    scan_out,
	input  pfp_pkg::cmd_t                     cmd,
	output pfp_pkg::frame_view_t              view
);
	import pfp_pkg::*;

	logic [PAGE_ID_BITS-1:0] page_q;
	logic [PIN_BITS-1:0]     pins_q;
	logic                    dirty_q;
	logic [STAMP_BITS-1:0]   stamp_q;
	logic                    sel;
	scan_t                   scan_d;
	scan_t                   scan_q;

	assign view     = '{page: page_q, pins: pins_q, dirty: dirty_q};
	assign sel      = (cmd.idx == my_idx);
	assign scan_out = scan_q;

	always_comb begin
		scan_d = scan_in;
		if (!scan_in.found && page_q == key) begin
			scan_d.found     = 1'b1;
			scan_d.found_idx = my_idx;
		end
		if (pins_q == '0 && (!scan_in.vic_ok || stamp_q <= scan_in.vic_stamp)) begin
			scan_d.vic_ok    = 1'b1;
			scan_d.vic_idx   = my_idx;
			scan_d.vic_stamp = stamp_q;
			scan_d.vic_dirty = dirty_q;
			scan_d.vic_page  = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '1;
			pins_q  <= '0;
			dirty_q <= 1'b0;
			stamp_q <= '0;
		end else if (sel) begin
			if (cmd.install) begin
				page_q  <= cmd.page;
				dirty_q <= cmd.dirty;
			end
			if (cmd.install || cmd.hit_upd)
				stamp_q <= cmd.stamp;
			if (cmd.pin_inc && pins_q != PIN_MAX)
				pins_q <= pins_q + 1'b1;
			if (cmd.pin_dec && pins_q != '0)
				pins_q <= pins_q - 1'b1;
			if (cmd.clean)
				dirty_q <= 1'b0;
		end
	end
endmodule
